[rtl/rubi_pkg.sv]
// Shared types and constants for the ray / unit box intersection block.
// No dependencies.
package rubi_pkg;

    localparam int FRAC_BITS = 24;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = 32;
    localparam int EPS_W     = 25;
    localparam int DIST_W    = 31;
    localparam int FACE_W    = 3;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int PROD_W    = COORD_W + MAG_W + 1;
    localparam int NFACES    = 6;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(168);

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } t_face;

    typedef struct packed {
        logic              found;
        logic [MAG_W-1:0]  nm;
        logic [MAG_W-1:0]  dm;
        logic [FACE_W-1:0] face;
    } t_cand;

endpackage

[rtl/rubi_lane.sv]
// One face lane: plane distance, epsilon test and bounds test on the other axes.
// Depends on rubi_pkg.
module rubi_lane (
    input  logic                            i_clk,
    input  logic [rubi_pkg::COORD_W-1:0]    i_o_a,
    input  logic [rubi_pkg::COORD_W-1:0]    i_d_a,
    input  logic [rubi_pkg::COORD_W-1:0]    i_o_b,
    input  logic [rubi_pkg::COORD_W-1:0]    i_d_b,
    input  logic [rubi_pkg::COORD_W-1:0]    i_o_c,
    input  logic [rubi_pkg::COORD_W-1:0]    i_d_c,
    input  logic                            i_neg,
    input  logic [rubi_pkg::FACE_W-1:0]     i_face,
    input  logic [rubi_pkg::EPS_W-1:0]      i_min_dist,
    output rubi_pkg::t_cand                 o_cand
);
    import rubi_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [COORD_W:0] HALF = (COORD_W+1)'(1) <<< (FRAC_BITS - 1);

    // stage A
    logic signed [COORD_W:0] n_diff;
    logic [MAG_W-1:0] n_nm, n_dm;
    logic n_ok;
    logic r_ok;
    logic [MAG_W-1:0] r_nm, r_dm;
    logic [COORD_W-1:0] r_ob, r_db, r_oc, r_dc;
    logic [FACE_W-1:0] r_face;

    // stage B
    logic [MAG_W+EPS_W-1:0] r_eps_p;
    logic signed [PROD_W-1:0] r_pb1, r_pb2, r_pc1, r_pc2;
    logic r_ok_b;
    logic [MAG_W-1:0] r_nm_b, r_dm_b;
    logic [FACE_W-1:0] r_face_b;

    // stage C
    logic signed [SUM_W-1:0] n_sb, n_sc, n_hd;
    logic n_inb, n_inc, n_epsok;

    always_comb begin
        n_diff = (i_neg ? -HALF : HALF) - $signed({i_o_a[COORD_W-1], i_o_a});
        n_nm   = n_diff[COORD_W] ? MAG_W'(-n_diff) : n_diff[MAG_W-1:0];
        n_dm   = i_d_a[COORD_W-1] ? MAG_W'(-$signed({i_d_a[COORD_W-1], i_d_a}))
                                  : i_d_a;
        n_ok   = (i_d_a != '0) && (n_diff != '0) && (n_diff[COORD_W] == i_d_a[COORD_W-1]);
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_nm   <= n_nm;
        r_dm   <= n_dm;
        r_ob   <= i_o_b;
        r_db   <= i_d_b;
        r_oc   <= i_o_c;
        r_dc   <= i_d_c;
        r_face <= i_face;
    end

    always_ff @(posedge i_clk) begin
        r_eps_p  <= (MAG_W+EPS_W)'(i_min_dist) * (MAG_W+EPS_W)'(r_dm);
        r_pb1    <= PROD_W'($signed(r_ob)) * PROD_W'($signed({1'b0, r_dm}));
        r_pb2    <= PROD_W'($signed({1'b0, r_nm})) * PROD_W'($signed(r_db));
        r_pc1    <= PROD_W'($signed(r_oc)) * PROD_W'($signed({1'b0, r_dm}));
        r_pc2    <= PROD_W'($signed({1'b0, r_nm})) * PROD_W'($signed(r_dc));
        r_ok_b   <= r_ok;
        r_nm_b   <= r_nm;
        r_dm_b   <= r_dm;
        r_face_b <= r_face;
    end

    always_comb begin
        n_sb    = SUM_W'(r_pb1) + SUM_W'(r_pb2);
        n_sc    = SUM_W'(r_pc1) + SUM_W'(r_pc2);
        n_hd    = $signed(SUM_W'({r_dm_b, {(FRAC_BITS-1){1'b0}}}));
        n_inb   = (n_sb >= -n_hd) && (n_sb <= n_hd);
        n_inc   = (n_sc >= -n_hd) && (n_sc <= n_hd);
        n_epsok = (MAG_W+EPS_W)'({r_nm_b, {FRAC_BITS{1'b0}}}) > r_eps_p;
    end

    always_ff @(posedge i_clk) begin
        o_cand.found <= r_ok_b && n_epsok && n_inb && n_inc;
        o_cand.nm    <= r_nm_b;
        o_cand.dm    <= r_dm_b;
        o_cand.face  <= r_face_b;
    end

endmodule

[rtl/rubi_merge.sv]
// Registered tree that keeps the nearest candidate, earlier face on a tie.
// Depends on rubi_pkg.
module rubi_merge (
    input  logic                    i_clk,
    input  rubi_pkg::t_cand         i_cand [rubi_pkg::NFACES],
    output rubi_pkg::t_cand         o_best
);
    import rubi_pkg::*;

    localparam int XW = 2 * MAG_W;

    function automatic t_cand pick(t_cand l, t_cand r, logic [XW-1:0] pl, logic [XW-1:0] pr);
        pick = (r.found && (!l.found || pr < pl)) ? r : l;
    endfunction

    t_cand r_c1 [NFACES];
    logic [XW-1:0] r_p1l [3], r_p1r [3];
    t_cand r_w2 [3];
    t_cand r_c3 [3];
    logic [XW-1:0] r_p3l, r_p3r;
    t_cand r_w4 [2];
    t_cand r_c5 [2];
    logic [XW-1:0] r_p5l, r_p5r;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c1[2*k]   <= i_cand[2*k];
            r_c1[2*k+1] <= i_cand[2*k+1];
            r_p1l[k]    <= XW'(i_cand[2*k].nm) * XW'(i_cand[2*k+1].dm);
            r_p1r[k]    <= XW'(i_cand[2*k+1].nm) * XW'(i_cand[2*k].dm);
        end
        for (int k = 0; k < 3; k++) begin
            r_w2[k] <= pick(r_c1[2*k], r_c1[2*k+1], r_p1l[k], r_p1r[k]);
        end
        r_c3  <= r_w2;
        r_p3l <= XW'(r_w2[0].nm) * XW'(r_w2[1].dm);
        r_p3r <= XW'(r_w2[1].nm) * XW'(r_w2[0].dm);
        r_w4[0] <= pick(r_c3[0], r_c3[1], r_p3l, r_p3r);
        r_w4[1] <= r_c3[2];
        r_c5  <= r_w4;
        r_p5l <= XW'(r_w4[0].nm) * XW'(r_w4[1].dm);
        r_p5r <= XW'(r_w4[1].nm) * XW'(r_w4[0].dm);
        o_best <= pick(r_c5[0], r_c5[1], r_p5l, r_p5r);
    end

endmodule

[rtl/rubi_div.sv]
// Pipelined restoring divider: one quotient bit per stage, saturating distance.
// Depends on rubi_pkg.
module rubi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  rubi_pkg::t_cand             i_best,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [rubi_pkg::DIST_W-1:0] o_distance,
    output logic [rubi_pkg::FACE_W-1:0] o_face
);
    import rubi_pkg::*;

    localparam int NST = DIST_W + 1;

    logic [NUM_W-1:0] n_num;
    logic             r_v    [NST];
    logic [MAG_W-1:0] r_rem  [NST];
    logic [DIST_W-1:0] r_low [NST];
    logic [DIST_W-1:0] r_q   [NST];
    logic [MAG_W-1:0] r_den  [NST];
    logic             r_sat  [NST];
    logic             r_hit  [NST];
    logic [FACE_W-1:0] r_face [NST];

    assign n_num = {i_best.nm, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]  <= MAG_W'(n_num[NUM_W-1:DIST_W]);
        r_low[0]  <= n_num[DIST_W-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= i_best.dm;
        r_sat[0]  <= MAG_W'(n_num[NUM_W-1:DIST_W]) >= i_best.dm;
        r_hit[0]  <= i_best.found;
        r_face[0] <= i_best.face;
    end

    for (genvar k = 0; k < DIST_W; k++) begin : g_step
        logic [MAG_W:0] n_t;
        logic           n_ge;
        assign n_t  = {r_rem[k], r_low[k][DIST_W-1]};
        assign n_ge = n_t >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1]  <= n_ge ? MAG_W'(n_t - {1'b0, r_den[k]}) : n_t[MAG_W-1:0];
            r_low[k+1]  <= {r_low[k][DIST_W-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][DIST_W-2:0], n_ge};
            r_den[k+1]  <= r_den[k];
            r_sat[k+1]  <= r_sat[k];
            r_hit[k+1]  <= r_hit[k];
            r_face[k+1] <= r_face[k];
        end
    end

    // drop the distance and face when nothing was hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[NST-1];
        end
        o_hit      <= r_hit[NST-1];
        o_distance <= !r_hit[NST-1] ? '0 : (r_sat[NST-1] ? '1 : r_q[NST-1]);
        o_face     <= r_hit[NST-1] ? r_face[NST-1] : FACE_PX;
    end

endmodule

[rtl/ray_unit_box_intersect_top.sv]
// Ray against the unit cube centred on the origin, six face lanes in parallel.
// A result passes through the lane stages, the merge tree and the divider before o_strobe.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// The distance divider resolves one quotient bit per stage, which sets the depth.
// Reset clears the valid pipeline and loads min_distance with 168.
// Depends on rubi_pkg, rubi_lane, rubi_merge, rubi_div.
module ray_unit_box_intersect_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rubi_pkg::COORD_W-1:0]    i_origin_x,
    input  logic [rubi_pkg::COORD_W-1:0]    i_origin_y,
    input  logic [rubi_pkg::COORD_W-1:0]    i_origin_z,
    input  logic [rubi_pkg::COORD_W-1:0]    i_dir_x,
    input  logic [rubi_pkg::COORD_W-1:0]    i_dir_y,
    input  logic [rubi_pkg::COORD_W-1:0]    i_dir_z,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rubi_pkg::EPS_W-1:0]      i_cfg_data,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic [rubi_pkg::DIST_W-1:0]     o_distance,
    output logic [rubi_pkg::FACE_W-1:0]     o_face
);
    import rubi_pkg::*;

    localparam int LANE_LAT  = 3;
    localparam int MERGE_LAT = 6;
    localparam int VPIPE     = LANE_LAT + MERGE_LAT;

    logic [EPS_W-1:0] r_min_dist;
    logic [VPIPE-1:0] r_vpipe;
    logic [COORD_W-1:0] w_o [3];
    logic [COORD_W-1:0] w_d [3];
    t_cand w_cand [NFACES];
    t_cand w_best;

    // the pipeline always takes a new transaction
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign w_o[0] = i_origin_x;
    assign w_o[1] = i_origin_y;
    assign w_o[2] = i_origin_z;
    assign w_d[0] = i_dir_x;
    assign w_d[1] = i_dir_y;
    assign w_d[2] = i_dir_z;

    // epsilon register; the user must write it only while the pipeline is empty, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_dist <= i_cfg_data;
        end
    end

    // advance the valid marker alongside the lanes and merge tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[VPIPE-2:0], start && !busy};
        end
    end

    // face f tests axis f/2 against the plane at +0.5 (even) or -0.5 (odd)
    for (genvar f = 0; f < NFACES; f++) begin : g_lane
        rubi_lane u_lane (
            .i_clk      (i_clk),
            .i_o_a      (w_o[f/2]),
            .i_d_a      (w_d[f/2]),
            .i_o_b      (w_o[(f/2+1)%3]),
            .i_d_b      (w_d[(f/2+1)%3]),
            .i_o_c      (w_o[(f/2+2)%3]),
            .i_d_c      (w_d[(f/2+2)%3]),
            .i_neg      (1'(f % 2)),
            .i_face     (FACE_W'(f)),
            .i_min_dist (r_min_dist),
            .o_cand     (w_cand[f])
        );
    end

    rubi_merge u_merge (
        .i_clk  (i_clk),
        .i_cand (w_cand),
        .o_best (w_best)
    );

    rubi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vpipe[VPIPE-1]),
        .i_best     (w_best),
        .o_valid    (o_strobe),
        .o_hit      (o_hit),
        .o_distance (o_distance),
        .o_face     (o_face)
    );

endmodule
